[rtl/pr3d_pkg.sv]
package pr3d_pkg;

  // Pipeline depth from an accepted start beat to its done strobe.
  localparam int unsigned NumStages = 9;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCenterX      = 3'd0,
    CfgCenterY      = 3'd1,
    CfgCenterZ      = 3'd2,
    CfgAxisFirst    = 3'd3,
    CfgAxisSecond   = 3'd4,
    CfgExtentFirst  = 3'd5,
    CfgExtentSecond = 3'd6
  } cfg_reg_e;

  localparam logic [47:0] AxisFirstRst  = 48'h0000_0000_4000;
  localparam logic [47:0] AxisSecondRst = 48'h0000_4000_0000;
  localparam logic [30:0] ExtentRst     = 31'h0001_0000;

endpackage

[rtl/point_rectangle_sq_distance_3d.sv]
// Channel   Direction  Handshake                   Payload
// query     in         start_i & !busy_o           point, time_step, point/rect velocity
// result    out        done_o, one cycle strobe    sq_distance, nearest, rect_coord
// config    in         cfg_valid_i & cfg_ready_o   cfg_index_i, cfg_data_i
//
// Nine register stages: an accepted query shows its result with done_o after the last
// stage. busy_o stays low, so a new query can enter every cycle and
// one result leaves every cycle. The depth is set by the three multiply levels, the
// rounding and clamping between them and the wide squared-distance sum. Reset loads
// the configuration reset values and clears the valid bits; results must be taken
// in the cycle they are shown.
module point_rectangle_sq_distance_3d (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [31:0]                   point_x_i,
  input  logic signed [31:0]                   point_y_i,
  input  logic signed [31:0]                   point_z_i,
  input  logic signed [31:0]                   time_step_i,
  input  logic signed [31:0]                   point_vel_x_i,
  input  logic signed [31:0]                   point_vel_y_i,
  input  logic signed [31:0]                   point_vel_z_i,
  input  logic signed [31:0]                   rect_vel_x_i,
  input  logic signed [31:0]                   rect_vel_y_i,
  input  logic signed [31:0]                   rect_vel_z_i,
  output logic                                 done_o,
  output logic        [63:0]                   sq_distance_o,
  output logic signed [31:0]                   nearest_x_o,
  output logic signed [31:0]                   nearest_y_o,
  output logic signed [31:0]                   nearest_z_o,
  output logic signed [31:0]                   rect_coord_first_o,
  output logic signed [31:0]                   rect_coord_second_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [pr3d_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [pr3d_pkg::CfgDataW-1:0] cfg_data_i
);

  function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
    logic signed [31:0] r;
    if (x > 49'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -49'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [31:0] center_q [3];
  logic        [47:0] axis_first_q, axis_second_q;
  logic        [30:0] extent_first_q, extent_second_q;

  logic [pr3d_pkg::NumStages-1:0] vld_q;
  logic                           accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0]     <= '0;
      center_q[1]     <= '0;
      center_q[2]     <= '0;
      axis_first_q    <= pr3d_pkg::AxisFirstRst;
      axis_second_q   <= pr3d_pkg::AxisSecondRst;
      extent_first_q  <= pr3d_pkg::ExtentRst;
      extent_second_q <= pr3d_pkg::ExtentRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pr3d_pkg::CfgCenterX:      center_q[0]     <= cfg_data_i[31:0];
        pr3d_pkg::CfgCenterY:      center_q[1]     <= cfg_data_i[31:0];
        pr3d_pkg::CfgCenterZ:      center_q[2]     <= cfg_data_i[31:0];
        pr3d_pkg::CfgAxisFirst:    axis_first_q    <= cfg_data_i[47:0];
        pr3d_pkg::CfgAxisSecond:   axis_second_q   <= cfg_data_i[47:0];
        pr3d_pkg::CfgExtentFirst:  extent_first_q  <= cfg_data_i[30:0];
        pr3d_pkg::CfgExtentSecond: extent_second_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[pr3d_pkg::NumStages-2:0], accept};
    end
  end

  logic signed [31:0] pos_in [3];
  logic signed [31:0] pvel_in [3];
  logic signed [31:0] rvel_in [3];
  logic signed [15:0] ax0 [3];
  logic signed [15:0] ax1 [3];

  assign pos_in[0]  = point_x_i;
  assign pos_in[1]  = point_y_i;
  assign pos_in[2]  = point_z_i;
  assign pvel_in[0] = point_vel_x_i;
  assign pvel_in[1] = point_vel_y_i;
  assign pvel_in[2] = point_vel_z_i;
  assign rvel_in[0] = rect_vel_x_i;
  assign rvel_in[1] = rect_vel_y_i;
  assign rvel_in[2] = rect_vel_z_i;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign ax0[k] = axis_first_q[16*k +: 16];
    assign ax1[k] = axis_second_q[16*k +: 16];
  end

  // Stage 1: time times velocity.
  logic signed [63:0] pm_d [3], pm_q [3];
  logic signed [63:0] rm_d [3], rm_q [3];
  logic signed [31:0] pos1_q [3];
  // Stage 2: moved point and center.
  logic signed [31:0] p_d [3], p2_q [3];
  logic signed [31:0] c_d [3], c2_q [3];
  // Stage 3: difference.
  logic signed [32:0] d_d [3], d3_q [3];
  logic signed [31:0] c3_q [3];
  // Stage 4: products of the difference.
  logic signed [65:0] dd_d [3], dd4_q [3];
  logic signed [48:0] da0_d [3], da0_q [3];
  logic signed [48:0] da1_d [3], da1_q [3];
  logic signed [31:0] c4_q [3];
  // Stage 5: projections and |d|^2.
  logic signed [36:0] b_d [2], b5_q [2];
  logic signed [67:0] sq_d, sq5_q;
  logic signed [31:0] c5_q [3];
  // Stage 6: clamped coordinates and s + 2b.
  logic signed [31:0] s_d [2], s6_q [2];
  logic signed [38:0] t_d [2], t6_q [2];
  logic signed [67:0] sq6_q;
  logic signed [31:0] c6_q [3];
  // Stage 7: partial products.
  logic signed [51:0] ph_d [2], ph7_q [2];
  logic signed [51:0] pl_d [2], pl7_q [2];
  logic signed [47:0] so0_d [3], so0_q [3];
  logic signed [47:0] so1_d [3], so1_q [3];
  logic signed [31:0] s7_q [2];
  logic signed [67:0] sq7_q;
  logic signed [31:0] c7_q [3];
  // Stage 8: correction terms and nearest point.
  logic signed [70:0] st_d [2], st8_q [2];
  logic signed [31:0] near_d [3], near8_q [3];
  logic signed [31:0] s8_q [2];
  logic signed [67:0] sq8_q;
  // Stage 9: output registers.
  logic        [63:0] dist_d, dist9_q;
  logic signed [31:0] near9_q [3];
  logic signed [31:0] s9_q [2];

  always_comb begin
    logic signed [63:0] rnd_p, rnd_c;
    logic signed [50:0] dot;
    logic signed [37:0] nb, ext;
    logic signed [47:0] off;
    logic signed [72:0] acc;

    for (int k = 0; k < 3; k++) begin
      pm_d[k] = time_step_i * pvel_in[k];
      rm_d[k] = time_step_i * rvel_in[k];

      // Round half up from Q32.32 to Q16.16, then add and saturate.
      rnd_p  = pm_q[k] + 64'sd32768;
      rnd_c  = rm_q[k] + 64'sd32768;
      p_d[k] = sat32(49'(pos1_q[k]) + 49'($signed(rnd_p[63:16])));
      c_d[k] = sat32(49'(center_q[k]) + 49'($signed(rnd_c[63:16])));

      d_d[k] = 33'(c2_q[k]) - 33'(p2_q[k]);

      dd_d[k]  = d3_q[k] * d3_q[k];
      da0_d[k] = d3_q[k] * ax0[k];
      da1_d[k] = d3_q[k] * ax1[k];
    end

    dot    = 51'(da0_q[0]) + 51'(da0_q[1]) + 51'(da0_q[2]) + 51'sd8192;
    b_d[0] = dot[50:14];
    dot    = 51'(da1_q[0]) + 51'(da1_q[1]) + 51'(da1_q[2]) + 51'sd8192;
    b_d[1] = dot[50:14];
    sq_d   = 68'(dd4_q[0]) + 68'(dd4_q[1]) + 68'(dd4_q[2]);

    for (int j = 0; j < 2; j++) begin
      nb  = -38'(b5_q[j]);
      ext = (j == 0) ? $signed({7'd0, extent_first_q}) : $signed({7'd0, extent_second_q});
      if (nb < -ext) begin
        nb = -ext;
      end else if (nb > ext) begin
        nb = ext;
      end
      s_d[j] = nb[31:0];
      t_d[j] = 39'(nb) + (39'(b5_q[j]) <<< 1);

      // s * (s + 2b) split into a signed upper and an unsigned lower slice.
      ph_d[j] = s6_q[j] * $signed(t6_q[j][38:19]);
      pl_d[j] = s6_q[j] * $signed({1'b0, t6_q[j][18:0]});

      st_d[j] = (71'(ph7_q[j]) <<< 19) + 71'(pl7_q[j]);
    end

    for (int k = 0; k < 3; k++) begin
      so0_d[k] = s6_q[0] * ax0[k];
      so1_d[k] = s6_q[1] * ax1[k];

      off       = so0_q[k] + so1_q[k] + 48'sd8192;
      near_d[k] = sat32(49'(c7_q[k]) + 49'($signed(off[47:14])));
    end

    // Negative sums clamp to zero; anything from 2^64 up saturates.
    acc = 73'(sq8_q) + 73'(st8_q[0]) + 73'(st8_q[1]);
    if (acc[72]) begin
      dist_d = '0;
    end else if (acc[71:64] != 8'd0) begin
      dist_d = '1;
    end else begin
      dist_d = acc[63:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pm_q[k]    <= pm_d[k];
      rm_q[k]    <= rm_d[k];
      pos1_q[k]  <= pos_in[k];
      p2_q[k]    <= p_d[k];
      c2_q[k]    <= c_d[k];
      d3_q[k]    <= d_d[k];
      c3_q[k]    <= c2_q[k];
      dd4_q[k]   <= dd_d[k];
      da0_q[k]   <= da0_d[k];
      da1_q[k]   <= da1_d[k];
      c4_q[k]    <= c3_q[k];
      c5_q[k]    <= c4_q[k];
      c6_q[k]    <= c5_q[k];
      so0_q[k]   <= so0_d[k];
      so1_q[k]   <= so1_d[k];
      c7_q[k]    <= c6_q[k];
      near8_q[k] <= near_d[k];
      near9_q[k] <= near8_q[k];
    end
    for (int j = 0; j < 2; j++) begin
      b5_q[j]  <= b_d[j];
      s6_q[j]  <= s_d[j];
      t6_q[j]  <= t_d[j];
      ph7_q[j] <= ph_d[j];
      pl7_q[j] <= pl_d[j];
      s7_q[j]  <= s6_q[j];
      st8_q[j] <= st_d[j];
      s8_q[j]  <= s7_q[j];
      s9_q[j]  <= s8_q[j];
    end
    sq5_q   <= sq_d;
    sq6_q   <= sq5_q;
    sq7_q   <= sq6_q;
    sq8_q   <= sq7_q;
    dist9_q <= dist_d;
  end

  assign done_o              = vld_q[pr3d_pkg::NumStages-1];
  assign sq_distance_o       = dist9_q;
  assign nearest_x_o         = near9_q[0];
  assign nearest_y_o         = near9_q[1];
  assign nearest_z_o         = near9_q[2];
  assign rect_coord_first_o  = s9_q[0];
  assign rect_coord_second_o = s9_q[1];

endmodule
